// File: rtl/tacv_pkg.sv
`timescale 1ns / 1ps

package tacv_pkg;

	// Register map indexes (byte address is four times the index).
	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_POINT      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEGATIVE_EXTENT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_POSITIVE_EXTENT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INVERT_DIRECTION  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_ZONE_ON    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CENTRE_ZONE_WIDTH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CHANGE_THRESHOLD  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_AXIS_ENABLE       = 3'd7;

	// Register reset values.
	localparam logic signed [15:0] CENTER_POINT_RST    = 16'sd0;
	localparam logic signed [15:0] NEGATIVE_EXTENT_RST = -16'sd512;
	localparam logic signed [15:0] POSITIVE_EXTENT_RST = 16'sd512;
	localparam logic [4:0]         ZONE_WIDTH_RST      = 5'd8;
	localparam logic [3:0]         THRESHOLD_RST       = 4'd1;

	// Level arithmetic in unsigned Q7.8.
	localparam int unsigned LEVEL_W     = 15;
	localparam int unsigned VALUE_W     = 7;
	localparam logic [LEVEL_W-1:0] LEVEL_CENTRE = 15'd16384;
	localparam logic [13:0]        LEVEL_SWING  = 14'd16128;
	localparam logic [15:0]        ROUND_HALF   = 16'd128;
	localparam logic signed [23:0] ALPHA_NUM    = 24'sd77;
	localparam logic [13:0]        ZONE_GAIN    = 14'd63;
	localparam logic [5:0]         ZONE_FULL    = 6'd63;
	localparam logic [VALUE_W-1:0] VALUE_CENTRE = 7'd64;
	localparam logic [VALUE_W-1:0] VALUE_MAX    = 7'd127;

	// Shared divider geometry: the quotient is known to stay below 2**QUOT_W.
	localparam int unsigned DIVIDEND_W = 30;
	localparam int unsigned DIVISOR_W  = 16;
	localparam int unsigned QUOT_W     = 14;
	localparam int unsigned STEP_CNT_W = 4;

	typedef struct packed {
		logic signed [15:0] center_point;
		logic signed [15:0] negative_extent;
		logic signed [15:0] positive_extent;
		logic               invert_direction;
		logic               centre_zone_on;
		logic [4:0]         centre_zone_width;
		logic [3:0]         change_threshold;
		logic               axis_enable;
	} cfg_t;

	// State side effects of register writes.
	typedef struct packed {
		logic level_reset;
		logic last_reset;
	} cfg_evt_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_MUL1,
		S_DSTART1,
		S_DWAIT1,
		S_TARGET,
		S_ALPHA,
		S_UPDATE,
		S_ROUND,
		S_ZONE,
		S_MUL2,
		S_DSTART2,
		S_DWAIT2,
		S_ZFIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic scale;
		logic mul;
		logic zone_pass;
		logic div_start;
		logic target;
		logic alpha;
		logic update;
		logic round;
		logic zone;
		logic zfin;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic sat;
		logic div_busy;
		logic rescale;
		logic emit_needed;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/tacv_cfg.sv
`timescale 1ns / 1ps

module tacv_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tacv_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output tacv_pkg::cfg_t                 cfg,
	output tacv_pkg::cfg_evt_t             evt
);
	import tacv_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_point      <= CENTER_POINT_RST;
			cfg_q.negative_extent   <= NEGATIVE_EXTENT_RST;
			cfg_q.positive_extent   <= POSITIVE_EXTENT_RST;
			cfg_q.invert_direction  <= 1'b0;
			cfg_q.centre_zone_on    <= 1'b1;
			cfg_q.centre_zone_width <= ZONE_WIDTH_RST;
			cfg_q.change_threshold  <= THRESHOLD_RST;
			cfg_q.axis_enable       <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CENTER_POINT:      cfg_q.center_point      <= pwdata[15:0];
				REG_NEGATIVE_EXTENT:   cfg_q.negative_extent   <= pwdata[15:0];
				REG_POSITIVE_EXTENT:   cfg_q.positive_extent   <= pwdata[15:0];
				REG_INVERT_DIRECTION:  cfg_q.invert_direction  <= pwdata[0];
				REG_CENTRE_ZONE_ON:    cfg_q.centre_zone_on    <= pwdata[0];
				REG_CENTRE_ZONE_WIDTH: cfg_q.centre_zone_width <= pwdata[4:0];
				REG_CHANGE_THRESHOLD:  cfg_q.change_threshold  <= pwdata[3:0];
				REG_AXIS_ENABLE:       cfg_q.axis_enable       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Any invert write and an enable write of one restart the smoother.
	always_comb begin
		evt.level_reset = wr_en && ((idx == REG_INVERT_DIRECTION) ||
			((idx == REG_AXIS_ENABLE) && pwdata[0]));
		evt.last_reset  = wr_en && (idx == REG_AXIS_ENABLE) && pwdata[0];
	end

	// Read data mux.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_CENTER_POINT:      prdata = {{16{cfg_q.center_point[15]}}, cfg_q.center_point};
			REG_NEGATIVE_EXTENT:
				prdata = {{16{cfg_q.negative_extent[15]}}, cfg_q.negative_extent};
			REG_POSITIVE_EXTENT:
				prdata = {{16{cfg_q.positive_extent[15]}}, cfg_q.positive_extent};
			REG_INVERT_DIRECTION:  prdata = {31'd0, cfg_q.invert_direction};
			REG_CENTRE_ZONE_ON:    prdata = {31'd0, cfg_q.centre_zone_on};
			REG_CENTRE_ZONE_WIDTH: prdata = {27'd0, cfg_q.centre_zone_width};
			REG_CHANGE_THRESHOLD:  prdata = {28'd0, cfg_q.change_threshold};
			REG_AXIS_ENABLE:       prdata = {31'd0, cfg_q.axis_enable};
			default:               prdata = '0;
		endcase
	end

endmodule

// File: rtl/tacv_div.sv
`timescale 1ns / 1ps

module tacv_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tacv_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [tacv_pkg::DIVISOR_W-1:0]    divisor,
	output logic                              busy,
	output logic [tacv_pkg::QUOT_W-1:0]       quotient
);
	import tacv_pkg::*;

	logic                  busy_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [QUOT_W-1:0]     dvd_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign busy     = busy_q;
	assign quotient = quot_q;

	// One restoring step per cycle: the remainder always stays below the divisor.
	always_comb begin
		trial = {rem_q, dvd_q[QUOT_W-1]};
		fits  = trial >= {1'b0, divisor_q};
		diff  = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_CNT_W'(QUOT_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != STEP_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= dividend[DIVIDEND_W-1:QUOT_W];
			dvd_q     <= dividend[QUOT_W-1:0];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			dvd_q  <= {dvd_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

endmodule

// File: rtl/tacv_dp.sv
`timescale 1ns / 1ps

module tacv_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tacv_pkg::cfg_t                   cfg,
	input  tacv_pkg::cfg_evt_t               evt,
	input  tacv_pkg::dp_cmd_t                cmd,
	output tacv_pkg::dp_sts_t                sts,
	input  logic signed [15:0]               raw_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tacv_pkg::VALUE_W-1:0]     controller_value
);
	import tacv_pkg::*;

	// Sample and scaling registers.
	logic signed [15:0]   raw_q;
	logic [15:0]          mag_q;
	logic [15:0]          span_q;
	logic                 neg_q;
	logic                 sat_q;
	logic [DIVIDEND_W-1:0] prod_q;
	logic [LEVEL_W-1:0]   target_q;
	logic signed [23:0]   alpha_q;
	logic [VALUE_W-1:0]   value_q;
	logic [VALUE_W-1:0]   final_q;
	logic [VALUE_W-1:0]   zmag_q;
	logic                 zneg_q;

	// State that lives across samples.
	logic [LEVEL_W-1:0]   smoothed_q;
	logic [VALUE_W-1:0]   last_q;
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   out_value_q;

	// Scaling terms.
	logic signed [16:0]   centred;
	logic signed [16:0]   nspan_raw;
	logic signed [16:0]   pspan_raw;
	logic [15:0]          nspan;
	logic [15:0]          pspan;
	logic [15:0]          mag;
	logic [15:0]          span;

	// Multiplier and divider operands.
	logic [15:0]           mul_a;
	logic [13:0]           mul_b;
	logic [DIVISOR_W-1:0]  div_divisor;
	logic [QUOT_W-1:0]     quotient;
	logic                  div_busy;
	logic [5:0]            zspan;

	// Level update terms.
	logic [13:0]          swing;
	logic                 dir_neg;
	logic signed [16:0]   level_diff;
	logic signed [16:0]   level_sum;
	logic [15:0]          rounded;

	// Zone and emission terms.
	logic signed [7:0]    delta;
	logic signed [7:0]    wid;
	logic                 zone_hi;
	logic                 zone_lo;
	logic signed [7:0]    zone_mag;
	logic [7:0]           zone_out;
	logic [VALUE_W-1:0]   change;

	// Centre the sample and pick the span on its side, floored at one.
	always_comb begin
		centred   = 17'(raw_q) - 17'(cfg.center_point);
		nspan_raw = 17'(cfg.center_point) - 17'(cfg.negative_extent);
		pspan_raw = 17'(cfg.positive_extent) - 17'(cfg.center_point);
		nspan     = (nspan_raw < 17'sd1) ? 16'd1 : nspan_raw[15:0];
		pspan     = (pspan_raw < 17'sd1) ? 16'd1 : pspan_raw[15:0];
		mag       = centred[16] ? 16'(-centred) : centred[15:0];
		span      = centred[16] ? nspan : pspan;
	end

	// Shared multiplier and divider operand selection.
	always_comb begin
		zspan       = 6'(ZONE_FULL - {1'b0, cfg.centre_zone_width});
		mul_a       = cmd.zone_pass ? {9'd0, zmag_q} : mag_q;
		mul_b       = cmd.zone_pass ? ZONE_GAIN : LEVEL_SWING;
		div_divisor = cmd.zone_pass ? {10'd0, zspan} : span_q;
	end

	tacv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Target level and smoother step.
	always_comb begin
		swing      = sat_q ? LEVEL_SWING : quotient;
		dir_neg    = neg_q ^ cfg.invert_direction;
		level_diff = signed'({2'b00, target_q}) - signed'({2'b00, smoothed_q});
		level_sum  = signed'({2'b00, smoothed_q}) + 17'(alpha_q[23:8]);
		rounded    = {1'b0, smoothed_q} + ROUND_HALF;
	end

	// Centre zone decision on the rounded value.
	always_comb begin
		delta    = signed'({1'b0, value_q}) - signed'({1'b0, VALUE_CENTRE});
		wid      = signed'({3'b000, cfg.centre_zone_width});
		zone_hi  = delta > wid;
		zone_lo  = delta < -wid;
		zone_mag = zone_hi ? (delta - wid) : (-delta - wid);
		zone_out = zneg_q ? ({1'b0, VALUE_CENTRE} - {1'b0, quotient[VALUE_W-1:0]})
		                  : ({1'b0, VALUE_CENTRE} + {1'b0, quotient[VALUE_W-1:0]});
		change   = (final_q > last_q) ? (final_q - last_q) : (last_q - final_q);
	end

	always_comb begin
		sts.sat         = sat_q;
		sts.div_busy    = div_busy;
		sts.rescale     = cfg.centre_zone_on && (zone_hi || zone_lo);
		sts.emit_needed = (change >= {3'b000, cfg.change_threshold}) ||
			(final_q == VALUE_CENTRE);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// Per-sample working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q <= raw_sample;
		end
		if (cmd.scale) begin
			mag_q  <= mag;
			span_q <= span;
			neg_q  <= centred[16];
			sat_q  <= mag >= span;
		end
		if (cmd.mul) begin
			prod_q <= DIVIDEND_W'(mul_a) * DIVIDEND_W'(mul_b);
		end
		if (cmd.target) begin
			target_q <= dir_neg ? (LEVEL_CENTRE - {1'b0, swing})
			                    : (LEVEL_CENTRE + {1'b0, swing});
		end
		if (cmd.alpha) begin
			alpha_q <= 24'(level_diff) * ALPHA_NUM;
		end
		if (cmd.round) begin
			value_q <= (rounded[15:8] > {1'b0, VALUE_MAX}) ? VALUE_MAX : rounded[14:8];
		end
		if (cmd.zone) begin
			final_q <= cfg.centre_zone_on ? VALUE_CENTRE : value_q;
			zmag_q  <= zone_mag[VALUE_W-1:0];
			zneg_q  <= zone_lo;
		end
		if (cmd.zfin) begin
			final_q <= zone_out[VALUE_W-1:0];
		end
	end

	// Smoother level and last emitted value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= LEVEL_CENTRE;
			last_q     <= VALUE_CENTRE;
		end else begin
			if (evt.level_reset) begin
				smoothed_q <= LEVEL_CENTRE;
			end else if (cmd.update) begin
				smoothed_q <= level_sum[LEVEL_W-1:0];
			end
			if (evt.last_reset) begin
				last_q <= VALUE_CENTRE;
			end else if (cmd.emit) begin
				last_q <= final_q;
			end
		end
	end

	// Output register: a finished result waits here for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= final_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign controller_value = out_value_q;

endmodule

// File: rtl/tacv_ctrl.sv
`timescale 1ns / 1ps

module tacv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               axis_enable,
	input  tacv_pkg::dp_sts_t  sts,
	output tacv_pkg::dp_cmd_t  cmd
);
	import tacv_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && axis_enable) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE:   state_d = S_MUL1;
			S_MUL1:    state_d = sts.sat ? S_TARGET : S_DSTART1;
			S_DSTART1: state_d = S_DWAIT1;
			S_DWAIT1: begin
				if (!sts.div_busy) begin
					state_d = S_TARGET;
				end
			end
			S_TARGET:  state_d = S_ALPHA;
			S_ALPHA:   state_d = S_UPDATE;
			S_UPDATE:  state_d = S_ROUND;
			S_ROUND:   state_d = S_ZONE;
			S_ZONE:    state_d = sts.rescale ? S_MUL2 : S_EMIT;
			S_MUL2:    state_d = S_DSTART2;
			S_DSTART2: state_d = S_DWAIT2;
			S_DWAIT2: begin
				if (!sts.div_busy) begin
					state_d = S_ZFIN;
				end
			end
			S_ZFIN:    state_d = S_EMIT;
			S_EMIT: begin
				if (!sts.emit_needed || sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCALE:   cmd.scale = 1'b1;
			S_MUL1:    cmd.mul = 1'b1;
			S_DSTART1: cmd.div_start = 1'b1;
			S_DWAIT1:  ;
			S_TARGET:  cmd.target = 1'b1;
			S_ALPHA:   cmd.alpha = 1'b1;
			S_UPDATE:  cmd.update = 1'b1;
			S_ROUND:   cmd.round = 1'b1;
			S_ZONE:    cmd.zone = 1'b1;
			S_MUL2: begin
				cmd.mul       = 1'b1;
				cmd.zone_pass = 1'b1;
			end
			S_DSTART2: begin
				cmd.div_start = 1'b1;
				cmd.zone_pass = 1'b1;
			end
			S_DWAIT2:  cmd.zone_pass = 1'b1;
			S_ZFIN:    cmd.zfin = 1'b1;
			S_EMIT:    cmd.emit = sts.emit_needed && sts.out_free;
			default:   ;
		endcase
	end

endmodule

// File: rtl/tilt_axis_to_controller_value_core.sv
`timescale 1ns / 1ps
// The core takes a new sample only once it is done with the previous one. It runs
// the shared 14-step restoring divider for the span scaling unless the sample
// saturates, and once more when the centre zone rescales. Before a result goes out,
// the core waits while the previous result still waits for its transfer. Samples
// taken while the axis is disabled are accepted one per cycle and give no result.
// Reset: asynchronous, active low; registers return to their documented defaults,
// the smoother to 64.0 and the last emitted value to 64.

module tilt_axis_to_controller_value_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tacv_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              raw_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tacv_pkg::VALUE_W-1:0]    controller_value
);
	import tacv_pkg::*;

	cfg_t     cfg;
	cfg_evt_t evt;
	dp_cmd_t  cmd;
	dp_sts_t  sts;

	tacv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.evt     (evt)
	);

	tacv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.axis_enable (cfg.axis_enable),
		.sts         (sts),
		.cmd         (cmd)
	);

	tacv_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.evt              (evt),
		.cmd              (cmd),
		.sts              (sts),
		.raw_sample       (raw_sample),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.controller_value (controller_value)
	);

endmodule
